[hw/rtl/bhq_pkg.sv]
// Shared types, widths and operation codes for the bounded history queue.
`timescale 1ns / 1ps

package bhq_pkg;

    localparam int ID_BITS     = 16;
    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_W       = 7;
    localparam int POS_W       = 6;
    localparam int FUNC_W      = 3;
    localparam int CNT_OUT_W   = 7;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 7'd64;

    localparam logic [FUNC_W-1:0] FUNC_APPEND      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ        = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_NEW_ID      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TAKE_REPORT = 3'd4;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_POS = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ID_BITS-1:0] msg_id;
        logic [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        logic                 status;
        logic [ID_BITS-1:0]   read_id;
        logic [ID_BITS-1:0]   new_id;
        logic [CNT_OUT_W-1:0] count_now;
        logic                 report_valid;
        logic [ID_BITS-1:0]   report_id;
    } rsp_t;

endpackage

[hw/rtl/bhq_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bhq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/bhq_ctrl.sv]
// Queue sequencer: ring pointers, id counter, deletion report and RAM access control.
`timescale 1ns / 1ps

module bhq_ctrl #(
    parameter int DEPTH = bhq_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bhq_pkg::MAX_W-1:0] max_entries,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bhq_pkg::req_t             in_data,
    output logic                      res_valid,
    output bhq_pkg::rsp_t             res_data,
    input  logic                      res_take
);

    import bhq_pkg::*;

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int XW   = SW + 1;
    localparam int CMPW = (CW > MAX_W) ? CW : MAX_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_APP_EV  = 3'd1;
    localparam logic [2:0] S_RD_WAIT = 3'd2;
    localparam logic [2:0] S_REM1    = 3'd3;
    localparam logic [2:0] S_SHIFT   = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [PW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [ID_BITS-1:0] idc_reg, idc_next;
    logic               flag_reg, flag_next;
    logic [ID_BITS-1:0] val_reg, val_next;
    logic [CW-1:0]      c_reg, c_next;
    req_t               cur_reg, cur_next;
    rsp_t               res_reg, res_next;

    logic               we, re;
    logic [PW-1:0]      waddr, raddr;
    logic [ID_BITS-1:0] wdata, rdata;

    logic [CMPW-1:0] max_ext, cap, cnt_ext, pos_ext;
    logic            full, pos_bad, accept;
    logic [SW-1:0]   cnt_s, c1, c2;

    // Ring slot of a queue offset from the head; the offset never exceeds DEPTH.
    function automatic logic [PW-1:0] ring_at(input logic [PW-1:0] base,
                                              input logic [SW-1:0] off);
        logic [XW-1:0] sum;
        sum = XW'(base) + XW'(off);
        if (sum >= XW'(DEPTH))
        begin
            sum = sum - XW'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CW-1:0] n);
        logic [CMPW-1:0] e;
        e = CMPW'(n);
        return e[CNT_OUT_W-1:0];
    endfunction

    bhq_ram #(
        .WIDTH(ID_BITS),
        .DEPTH(DEPTH)
    ) u_slots (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    // A capacity of zero acts as one, anything above the ring size as the ring size.
    assign max_ext = CMPW'(max_entries);
    assign cap     = (max_ext == '0) ? CMPW'(1) :
                     (max_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : max_ext;
    assign cnt_ext = CMPW'(count_reg);
    assign pos_ext = CMPW'(in_data.position);
    assign full    = cnt_ext >= cap;
    assign pos_bad = pos_ext >= cnt_ext;

    assign cnt_s = SW'(count_reg);
    assign c1    = SW'(c_reg) + SW'(1);
    assign c2    = SW'(c_reg) + SW'(2);

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_EMIT);
    assign res_data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idc_next   = idc_reg;
        flag_next  = flag_reg;
        val_next   = val_reg;
        c_next     = c_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = ring_at(head_reg, cnt_s);
        wdata      = cur_reg.msg_id;
        re         = 1'b0;
        raddr      = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next              = in_data;
                    res_next.status       = STATUS_OK;
                    res_next.read_id      = '0;
                    res_next.new_id       = '0;
                    res_next.count_now    = cnt_out(count_reg);
                    res_next.report_valid = flag_reg;
                    res_next.report_id    = val_reg;
                    state_next            = S_EMIT;
                    case (in_data.func)
                        FUNC_APPEND:
                        begin
                            if (full)
                            begin
                                re         = 1'b1;
                                raddr      = head_reg;
                                state_next = S_APP_EV;
                            end
                            else
                            begin
                                we                 = 1'b1;
                                waddr              = ring_at(head_reg, cnt_s);
                                wdata              = in_data.msg_id;
                                count_next         = count_reg + 1'b1;
                                res_next.count_now = cnt_out(count_reg + 1'b1);
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (pos_bad)
                            begin
                                res_next.status = STATUS_BAD_POS;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = ring_at(head_reg, SW'(in_data.position));
                                c_next     = CW'(in_data.position);
                                state_next = S_REM1;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (pos_bad)
                            begin
                                res_next.status = STATUS_BAD_POS;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = ring_at(head_reg, SW'(in_data.position));
                                state_next = S_RD_WAIT;
                            end
                        end
                        FUNC_NEW_ID:
                        begin
                            res_next.new_id = idc_reg;
                            idc_next        = idc_reg + 1'b1;
                        end
                        FUNC_TAKE_REPORT:
                        begin
                            flag_next = 1'b0;
                            val_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_APP_EV:
            begin
                // The old head was read last cycle, so the new tail may reuse its slot.
                flag_next             = 1'b1;
                val_next              = rdata;
                head_next             = ring_at(head_reg, SW'(1));
                we                    = 1'b1;
                waddr                 = ring_at(head_reg, cnt_s);
                wdata                 = cur_reg.msg_id;
                res_next.report_valid = 1'b1;
                res_next.report_id    = rdata;
                state_next            = S_EMIT;
            end
            S_RD_WAIT:
            begin
                res_next.read_id = rdata;
                state_next       = S_EMIT;
            end
            S_REM1:
            begin
                flag_next             = 1'b1;
                val_next              = rdata;
                res_next.report_valid = 1'b1;
                res_next.report_id    = rdata;
                if (c1 < cnt_s)
                begin
                    re         = 1'b1;
                    raddr      = ring_at(head_reg, c1);
                    state_next = S_SHIFT;
                end
                else
                begin
                    count_next         = count_reg - 1'b1;
                    res_next.count_now = cnt_out(count_reg - 1'b1);
                    state_next         = S_EMIT;
                end
            end
            S_SHIFT:
            begin
                // rdata holds the entry behind the cursor; move it down one place.
                we     = 1'b1;
                waddr  = ring_at(head_reg, SW'(c_reg));
                wdata  = rdata;
                c_next = c_reg + 1'b1;
                if (c2 < cnt_s)
                begin
                    re    = 1'b1;
                    raddr = ring_at(head_reg, c2);
                end
                else
                begin
                    count_next         = count_reg - 1'b1;
                    res_next.count_now = cnt_out(count_reg - 1'b1);
                    state_next         = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            idc_reg   <= ID_BITS'(1);
            flag_reg  <= 1'b0;
            val_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idc_reg   <= idc_next;
            flag_reg  <= flag_next;
            val_reg   <= val_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    // The shift reads ahead of the write, so the two ports never meet on one slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (we && re) |-> (waddr != raddr))
        else $error("RAM read and write hit the same slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.func == FUNC_NEW_ID)) |=> (idc_reg == $past(idc_reg) + 1'b1))
        else $error("id counter did not advance after allocation");

    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != $past(head_reg)) |-> ($past(state_reg) == S_APP_EV))
        else $error("head moved outside an eviction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> $past(re))
        else $error("shift step without the read of its source entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg <= CW'(DEPTH)))
        else $error("entry count beyond ring size");

endmodule

[hw/rtl/bounded_history_queue_unit.sv]
// Top level of the bounded history queue: capacity register, sequencer and result register.
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_valid/cfg_ready  cfg_data: max_entries (7 bits)
//  in        in         in_valid/in_ready    in_data: func, msg_id, position
//  out       out        out_valid/out_ready  out_data: status .. report_id
//
// Take-id, take-report, unknown codes, bad positions and plain appends go straight from
// acceptance to the result; reads and evicting appends first pass S_RD_WAIT or S_APP_EV,
// since the slot RAM read port is registered. A removal at position p closes the gap by
// moving one entry per cycle through the RAM ports, count - 1 - p entries in all.
// The slot RAM needs no clearing after reset; the capacity resets to 64.
// A new transaction is taken while the previous result still waits in the output register.
`timescale 1ns / 1ps

module bounded_history_queue_unit #(
    parameter int DEPTH = bhq_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bhq_pkg::MAX_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bhq_pkg::req_t             in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bhq_pkg::rsp_t             out_data
);

    import bhq_pkg::*;

    logic [MAX_W-1:0] max_entries_reg, max_entries_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_data_reg;
    logic             res_valid, res_take;
    rsp_t             res_data;

    bhq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_entries(max_entries_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_take   (res_take)
    );

    assign cfg_ready = 1'b1;
    assign res_take  = res_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        max_entries_next = max_entries_reg;
        if (cfg_valid && cfg_ready)
        begin
            max_entries_next = cfg_data;
        end
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            max_entries_reg <= max_entries_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res_data;
        end
    end

endmodule
